// ===== design/dwfp_pkg.sv =====
// Shared types and constants for the depth-weighted fair price unit.
// No dependencies; every other file of the block refers to this package by scope.
`default_nettype none

package dwfp_pkg;

    // Configuration port
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;
    localparam logic REG_DECAY  = 1'b0;
    localparam logic REG_LEVELS = 1'b1;

    // Register fields and their values after reset
    localparam int DECAY_W  = 17;
    localparam int LEVELS_W = 7;
    localparam logic [DECAY_W-1:0]  DECAY_RESET  = 17'h08000;
    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 7'd5;

    // Level weight in Q1.16
    localparam int WEIGHT_W = 17;
    localparam int FRAC_W   = 16;
    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

    // Weighted quantity keeps this many fraction bits less than the raw product
    localparam int WQ_SHIFT = 8;

    // Accumulators and result
    localparam int NUM_W     = 64;
    localparam int DEN_W     = 48;
    localparam int FAIR_W    = 32;
    localparam int QUO_W     = 32;
    localparam int FIX_SHIFT = 8;
    localparam int STEP_W    = 5;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic fold;   // level lies within the folded depth of its side
        logic last;   // final level of a book update
    } item_ctl_t;

    typedef struct packed {
        logic done;   // one-cycle pulse when the quotient is ready
        logic ovf;    // quotient does not fit the result field
    } div_stat_t;

endpackage

`default_nettype wire

// ===== design/dwfp_front.sv =====
// Front part: accepts levels, tracks side and depth, and assigns each level its weight.
// Depends on dwfp_pkg; feeds dwfp_queue.
`default_nettype none

module dwfp_front #(
    parameter int MAX_LEVELS = 64,
    parameter int PRICE_BITS = 24,
    parameter int QTY_BITS   = 24,
    parameter int ENTRY_W    = 67
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic                          book_side,
    input  wire logic [PRICE_BITS-1:0]         level_price,
    input  wire logic [QTY_BITS-1:0]           level_qty,
    input  wire logic                          last_level,
    input  wire logic [dwfp_pkg::DECAY_W-1:0]  decay,
    input  wire logic [dwfp_pkg::LEVELS_W-1:0] levels_per_side,
    input  wire logic                          queue_full,
    output logic                               push,
    output logic [ENTRY_W-1:0]                 push_data
);

    localparam int LIM_MAX = (MAX_LEVELS < 127) ? MAX_LEVELS : 127;
    localparam int CNT_W   = $clog2(LIM_MAX + 1);
    localparam int MUL_W   = 2 * dwfp_pkg::WEIGHT_W;

    logic                              side_reg;
    logic                              started_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [dwfp_pkg::WEIGHT_W-1:0]     weight_reg;
    logic [dwfp_pkg::WEIGHT_W-1:0]     weight_next;

    logic                              accept;
    logic                              restart;
    logic [CNT_W-1:0]                  count_use;
    logic [dwfp_pkg::WEIGHT_W-1:0]     weight_use;
    logic [dwfp_pkg::LEVELS_W-1:0]     limit;
    logic [dwfp_pkg::DECAY_W-1:0]      decay_eff;
    logic [MUL_W-1:0]                  decay_prod;
    dwfp_pkg::item_ctl_t               ctl;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    // A new update or a change of side starts again at weight 1.0, depth 0.
    assign restart    = !started_reg || (book_side != side_reg);
    assign count_use  = restart ? '0 : count_reg;
    assign weight_use = restart ? dwfp_pkg::ONE_Q16 : weight_reg;

    assign limit = (levels_per_side > dwfp_pkg::LEVELS_W'(LIM_MAX))
                 ? dwfp_pkg::LEVELS_W'(LIM_MAX) : levels_per_side;
    assign decay_eff = (decay > dwfp_pkg::ONE_Q16) ? dwfp_pkg::ONE_Q16 : decay;

    assign ctl.fold = dwfp_pkg::LEVELS_W'(count_use) < limit;
    assign ctl.last = last_level;

    assign decay_prod = MUL_W'(weight_use) * MUL_W'(decay_eff);

    always_comb
    begin
        if (ctl.fold)
        begin
            count_next  = count_use + CNT_W'(1);
            weight_next = decay_prod[dwfp_pkg::FRAC_W + dwfp_pkg::WEIGHT_W - 1:dwfp_pkg::FRAC_W];
        end
        else
        begin
            count_next  = count_use;
            weight_next = weight_use;
        end
    end

    // Levels beyond the folded depth that do not close the update have no effect.
    assign push      = accept && (ctl.fold || ctl.last);
    assign push_data = {level_price, level_qty, weight_use, ctl};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg    <= 1'b0;
            started_reg <= 1'b0;
            count_reg   <= '0;
            weight_reg  <= dwfp_pkg::ONE_Q16;
        end
        else if (accept)
        begin
            side_reg    <= book_side;
            started_reg <= !last_level;
            count_reg   <= count_next;
            weight_reg  <= weight_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dwfp_queue.sv =====
// Short first-in first-out queue that decouples the front part from the back part.
// Depends on dwfp_pkg for its depth.
`default_nettype none

module dwfp_queue #(
    parameter int WIDTH = 67
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty,
    output logic                  full
);

    logic [WIDTH-1:0]              entry_reg [dwfp_pkg::QUEUE_DEPTH];
    logic [dwfp_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [dwfp_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [dwfp_pkg::QPTR_W:0]     count_reg;
    logic [dwfp_pkg::QPTR_W:0]     count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (dwfp_pkg::QPTR_W + 1)'(dwfp_pkg::QUEUE_DEPTH));
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/dwfp_div.sv =====
// Bit-serial restoring divider producing (num * 256) / den, one quotient bit a cycle.
// Depends on dwfp_pkg; used by dwfp_back.
`default_nettype none

module dwfp_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [dwfp_pkg::NUM_W-1:0]  num,
    input  wire logic [dwfp_pkg::DEN_W-1:0]  den,
    output dwfp_pkg::div_stat_t              stat,
    output logic [dwfp_pkg::QUO_W-1:0]       quotient
);

    localparam int LOW_W = dwfp_pkg::QUO_W - dwfp_pkg::FIX_SHIFT;
    localparam int CMP_W = dwfp_pkg::NUM_W + dwfp_pkg::FIX_SHIFT;

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } div_state_t;

    div_state_t                      state_reg;
    div_state_t                      state_next;
    logic [dwfp_pkg::STEP_W-1:0]     step_reg;
    logic                            done_reg;
    logic                            ovf_reg;
    logic [dwfp_pkg::DEN_W-1:0]      rem_reg;
    logic [dwfp_pkg::DEN_W-1:0]      den_reg;
    logic [dwfp_pkg::QUO_W-1:0]      shf_reg;

    logic [dwfp_pkg::DEN_W+1:0]      diff;
    logic                            pass;
    logic                            last_step;

    // The quotient overflows 32 bits exactly when num >= den * 2^24.
    logic                            ovf_next;
    assign ovf_next = {{dwfp_pkg::FIX_SHIFT{1'b0}}, num} >= CMP_W'({den, {LOW_W{1'b0}}});

    assign diff = {1'b0, rem_reg, shf_reg[dwfp_pkg::QUO_W-1]} - {2'b00, den_reg};
    assign pass = !diff[dwfp_pkg::DEN_W+1];
    assign last_step = (step_reg == dwfp_pkg::STEP_W'(dwfp_pkg::QUO_W - 1));

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign quotient  = shf_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (ovf_reg || last_step)
                begin
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_RUN) && (ovf_reg || last_step);
            if (state_reg == D_IDLE)
            begin
                step_reg <= '0;
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == D_IDLE) && start)
        begin
            // Start with the dividend's upper bits; they are below den when there is no overflow.
            rem_reg <= dwfp_pkg::DEN_W'(num[dwfp_pkg::NUM_W-1:LOW_W]);
            shf_reg <= {num[LOW_W-1:0], {dwfp_pkg::FIX_SHIFT{1'b0}}};
            den_reg <= den;
            ovf_reg <= ovf_next;
        end
        else if ((state_reg == D_RUN) && !ovf_reg)
        begin
            rem_reg <= pass ? diff[dwfp_pkg::DEN_W-1:0]
                            : {rem_reg[dwfp_pkg::DEN_W-2:0], shf_reg[dwfp_pkg::QUO_W-1]};
            shf_reg <= {shf_reg[dwfp_pkg::QUO_W-2:0], pass};
        end
    end

endmodule

`default_nettype wire

// ===== design/dwfp_back.sv =====
// Back part: weighs each queued level, accumulates the sums and produces the result word.
// Depends on dwfp_pkg and dwfp_div; reads from dwfp_queue.
`default_nettype none

module dwfp_back #(
    parameter int PRICE_BITS = 24,
    parameter int QTY_BITS   = 24,
    parameter int ENTRY_W    = 67
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        queue_empty,
    input  wire logic [ENTRY_W-1:0]          pop_data,
    output logic                             pop,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic [dwfp_pkg::FAIR_W-1:0]      fair_price,
    output logic                             fresh
);

    localparam int CTL_W  = $bits(dwfp_pkg::item_ctl_t);
    localparam int RAW_W  = QTY_BITS + dwfp_pkg::WEIGHT_W;
    localparam int WQ_W   = RAW_W - dwfp_pkg::WQ_SHIFT;
    localparam int LO_W   = (WQ_W + 1) / 2;
    localparam int HI_W   = WQ_W - LO_W;
    localparam int PLO_W  = LO_W + PRICE_BITS;
    localparam int PHI_W  = HI_W + PRICE_BITS;
    localparam int PROD_W = WQ_W + PRICE_BITS;
    localparam int PE_W   = (PROD_W > dwfp_pkg::NUM_W) ? PROD_W : dwfp_pkg::NUM_W + 1;

    typedef enum logic [7:0] {
        B_IDLE = 8'b00000001,
        B_MLO  = 8'b00000010,
        B_MHI  = 8'b00000100,
        B_ACC  = 8'b00001000,
        B_NUM  = 8'b00010000,
        B_LAST = 8'b00100000,
        B_DIV  = 8'b01000000,
        B_OUT  = 8'b10000000
    } back_state_t;

    back_state_t                      state_reg;
    back_state_t                      state_next;
    logic                             last_reg;
    logic                             pend_fresh_reg;
    logic [dwfp_pkg::NUM_W-1:0]       num_reg;
    logic [dwfp_pkg::DEN_W-1:0]       den_reg;
    logic [dwfp_pkg::FAIR_W-1:0]      held_reg;
    logic                             result_valid_reg;
    logic [dwfp_pkg::FAIR_W-1:0]      fair_price_reg;
    logic                             fresh_reg;

    logic [PRICE_BITS-1:0]            price_reg;
    logic [WQ_W-1:0]                  wq_reg;
    logic [PLO_W-1:0]                 plo_reg;
    logic [PHI_W-1:0]                 phi_reg;
    logic [dwfp_pkg::NUM_W-1:0]       prod_reg;

    dwfp_pkg::item_ctl_t              pop_ctl;
    logic [dwfp_pkg::WEIGHT_W-1:0]    pop_weight;
    logic [QTY_BITS-1:0]              pop_qty;
    logic [PRICE_BITS-1:0]            pop_price;
    logic [RAW_W-1:0]                 raw_prod;
    logic [PROD_W-1:0]                prod_full;
    logic [PE_W-1:0]                  prod_ext;
    logic [dwfp_pkg::NUM_W-1:0]       prod_next;
    logic [dwfp_pkg::DEN_W:0]         den_sum;
    logic [dwfp_pkg::DEN_W-1:0]       den_next;
    logic [dwfp_pkg::NUM_W:0]         num_sum;
    logic [dwfp_pkg::NUM_W-1:0]       num_next;
    logic                             out_free;
    logic                             div_start;
    dwfp_pkg::div_stat_t              div_stat;
    logic [dwfp_pkg::QUO_W-1:0]       div_quo;

    assign pop_ctl    = dwfp_pkg::item_ctl_t'(pop_data[CTL_W-1:0]);
    assign pop_weight = pop_data[CTL_W +: dwfp_pkg::WEIGHT_W];
    assign pop_qty    = pop_data[CTL_W + dwfp_pkg::WEIGHT_W +: QTY_BITS];
    assign pop_price  = pop_data[CTL_W + dwfp_pkg::WEIGHT_W + QTY_BITS +: PRICE_BITS];

    assign pop = (state_reg == B_IDLE) && !queue_empty;

    // Weighted quantity: the raw product has 16 fraction bits, of which wq keeps 8.
    assign raw_prod = RAW_W'(pop_weight) * RAW_W'(pop_qty);

    // The wide product wq * price is formed from two halves of wq.
    assign prod_full = (PROD_W'(phi_reg) << LO_W) + PROD_W'(plo_reg);
    assign prod_ext  = PE_W'(prod_full);
    assign prod_next = (|prod_ext[PE_W-1:dwfp_pkg::NUM_W]) ? '1 : prod_ext[dwfp_pkg::NUM_W-1:0];

    assign den_sum  = {1'b0, den_reg} + (dwfp_pkg::DEN_W + 1)'(wq_reg);
    assign den_next = den_sum[dwfp_pkg::DEN_W] ? '1 : den_sum[dwfp_pkg::DEN_W-1:0];
    assign num_sum  = {1'b0, num_reg} + {1'b0, prod_reg};
    assign num_next = num_sum[dwfp_pkg::NUM_W] ? '1 : num_sum[dwfp_pkg::NUM_W-1:0];

    assign out_free  = !result_valid_reg || !result_stall;
    assign div_start = (state_reg == B_LAST) && (den_reg != '0);

    dwfp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_reg),
        .den      (den_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    if (pop_ctl.fold)
                    begin
                        state_next = B_MLO;
                    end
                    else if (pop_ctl.last)
                    begin
                        state_next = B_LAST;
                    end
                end
            end
            B_MLO:
            begin
                state_next = B_MHI;
            end
            B_MHI:
            begin
                state_next = B_ACC;
            end
            B_ACC:
            begin
                state_next = B_NUM;
            end
            B_NUM:
            begin
                state_next = last_reg ? B_LAST : B_IDLE;
            end
            B_LAST:
            begin
                state_next = (den_reg != '0) ? B_DIV : B_OUT;
            end
            B_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            last_reg         <= 1'b0;
            pend_fresh_reg   <= 1'b0;
            num_reg          <= '0;
            den_reg          <= '0;
            held_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                last_reg <= pop_ctl.last;
            end
            if (state_reg == B_ACC)
            begin
                den_reg <= den_next;
            end
            if (state_reg == B_NUM)
            begin
                num_reg <= num_next;
            end
            if (state_reg == B_LAST)
            begin
                pend_fresh_reg <= 1'b0;
            end
            if ((state_reg == B_DIV) && div_stat.done)
            begin
                held_reg       <= div_stat.ovf ? '1 : div_quo;
                pend_fresh_reg <= 1'b1;
            end
            if ((state_reg == B_OUT) && out_free)
            begin
                result_valid_reg <= 1'b1;
                num_reg          <= '0;
                den_reg          <= '0;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            price_reg <= pop_price;
            wq_reg    <= raw_prod[RAW_W-1:dwfp_pkg::WQ_SHIFT];
        end
        if (state_reg == B_MLO)
        begin
            plo_reg <= PLO_W'(wq_reg[LO_W-1:0]) * PLO_W'(price_reg);
        end
        if (state_reg == B_MHI)
        begin
            phi_reg <= PHI_W'(wq_reg[WQ_W-1:LO_W]) * PHI_W'(price_reg);
        end
        if (state_reg == B_ACC)
        begin
            prod_reg <= prod_next;
        end
        if ((state_reg == B_OUT) && out_free)
        begin
            fair_price_reg <= held_reg;
            fresh_reg      <= pend_fresh_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign fair_price   = fair_price_reg;
    assign fresh        = fresh_reg;

endmodule

`default_nettype wire

// ===== design/depth_weighted_fair_price_unit.sv =====
// Top level of the depth-weighted fair price unit: configuration registers and wiring.
// Depends on dwfp_pkg, dwfp_front, dwfp_queue, dwfp_div and dwfp_back.
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------------
//  item      item_valid / item_stall   book_side, level_price, level_qty, last_level
//  result    result_valid / result_stall  fair_price, fresh
//  config    APB psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// The front part takes one level word per cycle while its four-entry queue has room.
// The back part pops a level only when idle; a level within the folded depth then passes
// B_MLO, B_MHI, B_ACC and B_NUM, a final level B_LAST, then B_DIV if its denominator is
// non-zero, where the bit-serial divider yields one quotient bit a cycle, and B_OUT.
// Reset clears all control state, the sums and the held price; the registers return
// to decay 0.5 and five levels a side. A stalled result word holds the back part only
// once it has the next result ready, and the front part goes on until the queue fills.
`default_nettype none

module depth_weighted_fair_price_unit #(
    parameter int MAX_LEVELS = 64,
    parameter int PRICE_BITS = 24,
    parameter int QTY_BITS   = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dwfp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dwfp_pkg::PDATA_W-1:0]  pwdata,
    output logic [dwfp_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,

    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic                          book_side,
    input  wire logic [PRICE_BITS-1:0]         level_price,
    input  wire logic [QTY_BITS-1:0]           level_qty,
    input  wire logic                          last_level,

    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [dwfp_pkg::FAIR_W-1:0]        fair_price,
    output logic                               fresh
);

    // Each queue word carries price, quantity, the level's weight and two control bits.
    localparam int ENTRY_W = PRICE_BITS + QTY_BITS + dwfp_pkg::WEIGHT_W
                           + $bits(dwfp_pkg::item_ctl_t);

    logic [dwfp_pkg::DECAY_W-1:0]   decay_reg;
    logic [dwfp_pkg::LEVELS_W-1:0]  levels_reg;
    logic                           cfg_write;
    logic                           reg_sel;

    logic                           push;
    logic [ENTRY_W-1:0]             push_data;
    logic                           pop;
    logic [ENTRY_W-1:0]             pop_data;
    logic                           queue_empty;
    logic                           queue_full;

    // Registers are decoded on the word address bit alone; the port never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[dwfp_pkg::PADDR_W-1];

    always_comb
    begin
        case (reg_sel)
            dwfp_pkg::REG_DECAY:
            begin
                prdata = dwfp_pkg::PDATA_W'(decay_reg);
            end
            dwfp_pkg::REG_LEVELS:
            begin
                prdata = dwfp_pkg::PDATA_W'(levels_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg  <= dwfp_pkg::DECAY_RESET;
            levels_reg <= dwfp_pkg::LEVELS_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                dwfp_pkg::REG_DECAY:
                begin
                    decay_reg <= pwdata[dwfp_pkg::DECAY_W-1:0];
                end
                dwfp_pkg::REG_LEVELS:
                begin
                    levels_reg <= pwdata[dwfp_pkg::LEVELS_W-1:0];
                end
                default:
                begin
                    decay_reg <= decay_reg;
                end
            endcase
        end
    end

    dwfp_front #(
        .MAX_LEVELS (MAX_LEVELS),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .book_side       (book_side),
        .level_price     (level_price),
        .level_qty       (level_qty),
        .last_level      (last_level),
        .decay           (decay_reg),
        .levels_per_side (levels_reg),
        .queue_full      (queue_full),
        .push            (push),
        .push_data       (push_data)
    );

    dwfp_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    dwfp_back #(
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .fair_price   (fair_price),
        .fresh        (fresh)
    );

endmodule

`default_nettype wire

// ===== tb/depth_weighted_fair_price_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the depth-weighted fair price unit.
// It needs only dwfp_pkg and depth_weighted_fair_price_unit. A built-in predictor checks
// every result word, first on a short directed table and then on random book updates.

module depth_weighted_fair_price_unit_test;

    import dwfp_pkg::*;

    // The block is built with its default sizes, and the predictor relies on them.
    localparam int MAX_LEVELS = 64;
    localparam int PRICE_BITS = 24;
    localparam int QTY_BITS   = 24;

    localparam int ITEM_TARGET   = 1150;      // level words that fold or end an update
    localparam int PHASE_ITEMS   = 110;       // level words between register settings
    localparam int IDLE_PCT      = 25;        // chance of an idle cycle on either side
    localparam int SETTLE_CYCLES = 100;       // covers the queue and a full division
    localparam int DRAIN_LIMIT   = 50000;
    localparam int TIMEOUT_NS    = 2_000_000; // bound on the whole run, in nanoseconds

    localparam logic [PADDR_W-1:0] DECAY_ADDR  = {REG_DECAY, 2'b00};
    localparam logic [PADDR_W-1:0] LEVELS_ADDR = {REG_LEVELS, 2'b00};

    localparam logic [DEN_W-1:0] DEN_LIMIT   = '1;
    localparam logic [63:0]      TICKS_LIMIT = 64'd1 << (FAIR_W - FIX_SHIFT);
    localparam int               PRICE_TOP   = (1 << PRICE_BITS) - 1;

    typedef struct packed {
        logic [FAIR_W-1:0] price;
        logic              fresh;
    } fair_word_t;

    // A row of the directed table is either one level word or a new pair of register
    // values, which is written once the block has gone idle.
    typedef enum logic {ROW_LEVEL, ROW_SETUP} plan_kind_e;

    typedef struct packed {
        plan_kind_e            kind;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
        logic                  last;
        logic                  typed;    // the expected word is written into the row
        fair_word_t            want;
        logic [DECAY_W-1:0]    decay_val;
        logic [LEVELS_W-1:0]   levels_val;
    } plan_row_t;

    localparam int PLAN_ROWS = 31;

    // Ports of the block
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  item_valid;
    logic                  item_stall;
    logic                  book_side;
    logic [PRICE_BITS-1:0] level_price;
    logic [QTY_BITS-1:0]   level_qty;
    logic                  last_level;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [FAIR_W-1:0]     fair_price;
    logic                  fresh;

    // Copy of the registers as the block should hold them.
    logic [DECAY_W-1:0]  cfg_decay;
    logic [LEVELS_W-1:0] cfg_levels;

    // State of the predictor: the weight of the next level, how many levels of the
    // current side have been folded, which side that is, and the running sums.
    logic [WEIGHT_W-1:0] fold_weight;
    int unsigned         fold_depth;
    logic                fold_side;
    logic                update_open;
    logic [NUM_W-1:0]    px_qty_sum;
    logic [DEN_W-1:0]    qty_sum;
    logic [FAIR_W-1:0]   held_fair;

    fair_word_t expected_fairs[$];
    plan_row_t  plan [0:PLAN_ROWS-1];
    int         levels_sent = 0;
    int         failures = 0;
    int         results_seen = 0;
    bit         steady = 1'b0;        // when set, neither side idles

    depth_weighted_fair_price_unit #(
        .MAX_LEVELS (MAX_LEVELS),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .book_side    (book_side),
        .level_price  (level_price),
        .level_qty    (level_qty),
        .last_level   (last_level),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .fair_price   (fair_price),
        .fresh        (fresh)
    );

    always #1 clk = ~clk;

    // The result side stalls at random, except during the steady stretch.
    always @(negedge clk)
    begin
        result_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("%s", what);
    endtask

    // Folds one level word into the predicted state exactly as the block should. A word
    // is produced only when the level closes the update. 'counted' tells the caller
    // whether the level did any work, so that ignored levels do not add to the total.
    function automatic void fold_book_level(input logic side, input logic [PRICE_BITS-1:0] price,
                                            input logic [QTY_BITS-1:0] qty, input logic last,
                                            output bit has_word, output fair_word_t word,
                                            output bit counted);
        int unsigned        depth_cap;
        logic [DECAY_W-1:0] factor;
        logic [63:0]        wq;
        logic [127:0]       prod;
        logic [64:0]        nsum;
        logic [63:0]        dsum;
        logic [63:0]        quo;
        logic [63:0]        rem;
        logic [63:0]        frac;

        has_word = 1'b0;
        word = '0;

        // A fresh update, or a change of side, starts again from a weight of one.
        if (!update_open || side != fold_side)
        begin
            fold_weight = ONE_Q16;
            fold_depth  = 0;
            fold_side   = side;
            update_open = 1'b1;
        end

        // Out-of-range settings are clipped: depth to MAX_LEVELS, decay to one.
        depth_cap = (cfg_levels > MAX_LEVELS) ? MAX_LEVELS : cfg_levels;
        factor    = (cfg_decay > ONE_Q16) ? ONE_Q16 : cfg_decay;
        counted   = last || (fold_depth < depth_cap);

        if (fold_depth < depth_cap)
        begin
            wq   = (64'(fold_weight) * 64'(qty)) >> WQ_SHIFT;
            prod = 128'(wq) * 128'(price);
            if (prod[127:64] != '0)
                prod = {64'd0, {64{1'b1}}};
            nsum = 65'(px_qty_sum) + 65'(prod[63:0]);
            px_qty_sum = nsum[64] ? '1 : nsum[63:0];
            dsum = 64'(qty_sum) + wq;
            qty_sum = (dsum > 64'(DEN_LIMIT)) ? DEN_LIMIT : dsum[DEN_W-1:0];
            fold_depth++;
            fold_weight = WEIGHT_W'((64'(fold_weight) * 64'(factor)) >> FRAC_W);
        end

        if (last)
        begin
            // An empty denominator repeats the held price and marks it as stale.
            if (qty_sum != '0)
            begin
                quo  = px_qty_sum / 64'(qty_sum);
                rem  = px_qty_sum % 64'(qty_sum);
                frac = (rem << FIX_SHIFT) / 64'(qty_sum);
                held_fair = (quo >= TICKS_LIMIT) ? '1 : FAIR_W'((quo << FIX_SHIFT) | frac);
                word.fresh = 1'b1;
            end
            word.price  = held_fair;
            px_qty_sum  = '0;
            qty_sum     = '0;
            update_open = 1'b0;
            has_word    = 1'b1;
        end
    endfunction

    // Offers one level word, with random idle cycles ahead of it unless the run is in its
    // steady stretch. The word is predicted at the edge that accepts it. The task starts
    // and ends at a falling edge and leaves valid high, so back-to-back words never drop it.
    task automatic send_level(input logic side, input logic [PRICE_BITS-1:0] price,
                              input logic [QTY_BITS-1:0] qty, input logic last,
                              input logic typed, input fair_word_t want);
        fair_word_t word;
        bit         has_word;
        bit         counted;

        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        book_side   <= side;
        level_price <= price;
        level_qty   <= qty;
        last_level  <= last;
        do
            @(posedge clk);
        while (item_stall);
        fold_book_level(side, price, qty, last, has_word, word, counted);
        if (has_word)
            expected_fairs.push_back(typed ? want : word);
        if (counted)
            levels_sent++;
        @(negedge clk);
    endtask

    // Stops offering words and waits until every expected result has come, then lets
    // 'extra' further cycles pass for levels that cause no result.
    task automatic drain_results(input int extra);
        item_valid <= 1'b0;
        @(negedge clk);
        while (expected_fairs.size() != 0)
            @(negedge clk);
        repeat (extra)
            @(negedge clk);
    endtask

    // One register write: a setup phase, then an access phase held until pready.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == DECAY_ADDR)
            cfg_decay = value[DECAY_W-1:0];
        else
            cfg_levels = value[LEVELS_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_book(input logic [DECAY_W-1:0] decay, input logic [LEVELS_W-1:0] levels);
        drain_results(SETTLE_CYCLES);
        write_reg(DECAY_ADDR, PDATA_W'(decay));
        write_reg(LEVELS_ADDR, PDATA_W'(levels));
    endtask

    function automatic plan_row_t lvl(input logic side, input int price, input int qty,
                                      input logic last);
        plan_row_t row;
        row = '0;
        row.kind  = ROW_LEVEL;
        row.side  = side;
        row.price = PRICE_BITS'(price);
        row.qty   = QTY_BITS'(qty);
        row.last  = last;
        return row;
    endfunction

    // A closing level whose result is obvious enough to be written down.
    function automatic plan_row_t lvl_exp(input logic side, input int price, input int qty,
                                          input logic [FAIR_W-1:0] want_price,
                                          input logic want_fresh);
        plan_row_t row;
        row = lvl(side, price, qty, 1'b1);
        row.typed      = 1'b1;
        row.want.price = want_price;
        row.want.fresh = want_fresh;
        return row;
    endfunction

    function automatic plan_row_t regs(input int decay, input int levels);
        plan_row_t row;
        row = '0;
        row.kind       = ROW_SETUP;
        row.decay_val  = DECAY_W'(decay);
        row.levels_val = LEVELS_W'(levels);
        return row;
    endfunction

    // Decay settings lean on the edges: zero, one, exactly 1.0 and values above 1.0.
    function automatic logic [DECAY_W-1:0] pick_decay();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DECAY_W'(1);
            2: return ONE_Q16;
            3: return DECAY_W'($urandom_range(32'h10001, 32'h1FFFF));
            4: return DECAY_RESET;
            default: return DECAY_W'($urandom_range(2, 32'hFFFF));
        endcase
    endfunction

    function automatic logic [LEVELS_W-1:0] pick_levels();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return LEVELS_W'(1);
            2: return LEVELS_W'(MAX_LEVELS);
            3: return LEVELS_W'($urandom_range(MAX_LEVELS + 1, 127));
            default: return LEVELS_W'($urandom_range(2, 10));
        endcase
    endfunction

    // Quantities are mostly modest, with empty levels and full-width values mixed in.
    function automatic logic [QTY_BITS-1:0] pick_qty();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return QTY_BITS'($urandom());
            default: return QTY_BITS'($urandom_range(1, 5000));
        endcase
    endfunction

    // A well-formed update is a run of bids at or below a mid price, then a run of asks
    // above it, with the last word marked. A broken one is a short run of random words whose
    // sides interleave and which may not end an update at all.
    task automatic send_book_update(input bit broken);
        int          depth_cap;
        int          n_bids;
        int          n_asks;
        int          mid;
        int          tick;
        int          px;
        int          n_noise;
        fair_word_t  none;

        none = '0;
        if (broken)
        begin
            n_noise = $urandom_range(1, 6);
            for (int i = 0; i < n_noise; i++)
                send_level($urandom_range(0, 1), PRICE_BITS'($urandom()), pick_qty(),
                           $urandom_range(0, 3) == 0, 1'b0, none);
        end
        else
        begin
            depth_cap = (cfg_levels > MAX_LEVELS) ? MAX_LEVELS : cfg_levels;
            // Most updates stay within ten levels a side; any update may run up to two past the folded depth.
            if ($urandom_range(0, 7) == 0)
                depth_cap = depth_cap + 2;
            else
                depth_cap = ((depth_cap < 8) ? depth_cap : 8) + 2;
            n_bids = $urandom_range(0, depth_cap);
            n_asks = $urandom_range(0, depth_cap);
            mid    = $urandom_range(0, PRICE_TOP);
            tick   = $urandom_range(1, 50);
            if (n_bids + n_asks == 0)
                send_level($urandom_range(0, 1), PRICE_BITS'(mid), '0, 1'b1, 1'b0, none);
            for (int i = 0; i < n_bids; i++)
            begin
                px = mid - i * tick;
                if (px < 0)
                    px = 0;
                send_level(1'b0, PRICE_BITS'(px), pick_qty(),
                           n_asks == 0 && i == n_bids - 1, 1'b0, none);
            end
            for (int i = 0; i < n_asks; i++)
            begin
                px = mid + 1 + i * tick;
                if (px > PRICE_TOP)
                    px = PRICE_TOP;
                send_level(1'b1, PRICE_BITS'(px), pick_qty(), i == n_asks - 1, 1'b0, none);
            end
        end
    endtask

    // Every accepted result word is held against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_fairs.size() == 0)
                note_failure($sformatf("result word %0d arrived with none expected: price %h fresh %b",
                                       results_seen, fair_price, fresh));
            else if (fair_price !== expected_fairs[0].price || fresh !== expected_fairs[0].fresh)
                note_failure($sformatf("result word %0d: expected price %h fresh %b, got price %h fresh %b",
                                       results_seen, expected_fairs[0].price,
                                       expected_fairs[0].fresh, fair_price, fresh));
            if (expected_fairs.size() != 0)
                void'(expected_fairs.pop_front());
            results_seen++;
        end
    end

    // A hung handshake or a missing result ends the run here.
    initial
    begin
        #TIMEOUT_NS;
        $display("depth_weighted_fair_price_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        int         phase;
        int         phase_start;
        int         updates;
        fair_word_t none;

        none        = '0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        item_valid  = 1'b0;
        book_side   = 1'b0;
        level_price = '0;
        level_qty   = '0;
        last_level  = 1'b0;

        cfg_decay   = DECAY_RESET;
        cfg_levels  = LEVELS_RESET;
        fold_weight = ONE_Q16;
        fold_depth  = 0;
        fold_side   = 1'b0;
        update_open = 1'b0;
        px_qty_sum  = '0;
        qty_sum     = '0;
        held_fair   = '0;

        // Directed table. The first rows run on the register values after reset: an
        // empty update before anything has been held, a single unit level at price 100,
        // an empty ask-only update that repeats it, and the extremes of price and
        // quantity. Then a full bid side that runs past the folded depth, asks after it,
        // and sides that interleave. The setup rows cover zero decay (only the first
        // level of a side counts), decay above 1.0, no folded levels at all (the held
        // price comes back stale), the smallest decay with a depth beyond the limit,
        // and a depth of one.
        plan = '{
            lvl_exp(1'b0, 0, 0, 32'h0000_0000, 1'b0),
            lvl_exp(1'b0, 100, 1, 32'h0000_6400, 1'b1),
            lvl_exp(1'b1, 0, 0, 32'h0000_6400, 1'b0),
            lvl_exp(1'b0, PRICE_TOP, 24'hFFFFFF, 32'hFFFF_FF00, 1'b1),
            lvl_exp(1'b1, 0, 24'hFFFFFF, 32'h0000_0000, 1'b1),
            lvl(1'b0, 1000, 50, 1'b0),
            lvl(1'b0, 999, 80, 1'b0),
            lvl(1'b0, 998, 120, 1'b0),
            lvl(1'b0, 997, 10, 1'b0),
            lvl(1'b0, 996, 300, 1'b0),
            lvl(1'b0, 995, 7777, 1'b0),
            lvl(1'b1, 1001, 40, 1'b0),
            lvl(1'b1, 1002, 60, 1'b1),
            lvl(1'b0, 500, 1, 1'b0),
            lvl(1'b1, 510, 1, 1'b0),
            lvl(1'b0, 505, 1, 1'b1),
            regs(0, 5),
            lvl(1'b0, 200, 10, 1'b0),
            lvl_exp(1'b0, 300, 1000, 32'h0000_C800, 1'b1),
            regs(32'h1FFFF, MAX_LEVELS),
            lvl(1'b0, 100, 1, 1'b0),
            lvl_exp(1'b0, 200, 1, 32'h0000_9600, 1'b1),
            regs(ONE_Q16, 0),
            lvl_exp(1'b1, 300, 5, 32'h0000_9600, 1'b0),
            regs(1, 127),
            lvl(1'b1, 700, 65535, 1'b0),
            lvl(1'b1, 800, 65535, 1'b1),
            regs(ONE_Q16, 1),
            lvl(1'b0, 10, 3, 1'b0),
            lvl(1'b0, 20, 3, 1'b0),
            lvl_exp(1'b1, 30, 3, 32'h0000_1400, 1'b1)
        };

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].kind == ROW_SETUP)
                program_book(plan[i].decay_val, plan[i].levels_val);
            else
                send_level(plan[i].side, plan[i].price, plan[i].qty, plan[i].last,
                           plan[i].typed, plan[i].want);
        end

        // Random phases, each on a fresh pair of register values. The second phase runs
        // with no idling on either side. Early in every phase the sender holds off until
        // all expected words have come back, so the block is seen running dry.
        phase = 0;
        while (levels_sent < ITEM_TARGET)
        begin
            program_book(pick_decay(), pick_levels());
            steady      = (phase == 1);
            phase_start = levels_sent;
            updates     = 0;
            while (levels_sent - phase_start < PHASE_ITEMS && levels_sent < ITEM_TARGET)
            begin
                send_book_update($urandom_range(0, 9) == 0);
                updates++;
                if (updates == 4)
                    drain_results(0);
            end
            steady = 1'b0;
            phase++;
        end

        // Wait for the last words, with a bound, then watch a while for strays.
        item_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && expected_fairs.size() != 0; w++)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (expected_fairs.size() != 0)
            note_failure($sformatf("%0d expected result words never arrived",
                                   expected_fairs.size()));

        if (failures == 0)
            $display("depth_weighted_fair_price_unit_test OK");
        else
            $display("depth_weighted_fair_price_unit_test NOT OK");
        $finish;
    end

endmodule
